@@ hw/rtl/pi_current_controller_antiwindup_unit_assert.svh @@
// assertion helpers for the pi current controller
`ifndef PI_CURRENT_CONTROLLER_ANTIWINDUP_UNIT_ASSERT_SVH
`define PI_CURRENT_CONTROLLER_ANTIWINDUP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define PICC_ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed: %m");

// check on every clock edge, reset included
`define PICC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed: %m");

`else

`define PICC_ASSERT_CLK(label, prop)
`define PICC_ASSERT_RST(label, prop)

`endif

`endif

@@ hw/rtl/picc_pkg.sv @@
`timescale 1ns / 1ps

package picc_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;

    // datapath widths
    localparam int SMP_W   = 16;  // q5.10 samples
    localparam int E_W     = 17;  // error, signed
    localparam int U_W     = 59;  // unclamped command, q.42
    localparam int DMAG_W  = 58;  // magnitude of clamp difference
    localparam int AW_W    = 60;  // anti-windup term magnitude
    localparam int ACC_W   = 62;  // integrator update sum
    localparam int INTEG_W = 48;  // integrator, q.42

    // configuration
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KP     = 3'd0;
    localparam t_cfg_idx CFG_KI_TS  = 3'd1;
    localparam t_cfg_idx CFG_KAW_TS = 3'd2;
    localparam t_cfg_idx CFG_VMAX   = 3'd3;
    localparam t_cfg_idx CFG_IMIN   = 3'd4;

    localparam logic [15:0] KP_RST     = 16'd2560;
    localparam logic [31:0] KI_TS_RST  = 32'd4295;
    localparam logic [31:0] KAW_TS_RST = 32'd0;
    localparam logic [14:0] VMAX_RST   = 15'd12288;
    localparam logic [14:0] IMIN_RST   = 15'd31;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

endpackage

@@ hw/rtl/picc_mul.sv @@
`timescale 1ns / 1ps

module picc_mul
    import picc_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    // unsigned 32x32 product, registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

@@ hw/rtl/pi_current_controller_antiwindup_unit.sv @@
`timescale 1ns / 1ps
// pi current controller with back-calculation anti-windup
// sequence: error check, kp*e, ki*e, clamp, two kaw partial products, sum, integrator
//   update, output; the deadband path skips to output; a new sample is taken only when idle;
//   a stalled output beat holds the sequencer in its output state; the single shared
//   32x32 multiplier forms kp*e, ki*e and two kaw partial products in turn
// reset: synchronous active low; integrator cleared, gains and limits to defaults
`include "pi_current_controller_antiwindup_unit_assert.svh"

module pi_current_controller_antiwindup_unit
    import picc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input samples
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // [15:0] current_ref, [31:16] current_meas
    // voltage commands
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // [15:0] voltage_cmd
    output logic [1:0]            m_axis_tuser   // [0] clamped, [1] deadband
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CHK  = 4'd1;
    localparam logic [3:0] ST_MKP  = 4'd2;
    localparam logic [3:0] ST_U    = 4'd3;
    localparam logic [3:0] ST_CLP  = 4'd4;
    localparam logic [3:0] ST_AWLO = 4'd5;
    localparam logic [3:0] ST_AWHI = 4'd6;
    localparam logic [3:0] ST_AWS  = 4'd7;
    localparam logic [3:0] ST_INT  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // configuration registers
    logic [15:0] r_kp;
    logic [31:0] r_ki;
    logic [31:0] r_kaw;
    logic [14:0] r_vmax;
    logic [14:0] r_imin;

    // control
    logic [3:0] r_state;
    logic       r_out_valid;

    // datapath
    logic signed [SMP_W-1:0]   r_ref;
    logic signed [SMP_W-1:0]   r_meas;
    logic [E_W-1:0]            r_emag;
    logic                      r_e_neg;
    logic signed [U_W-1:0]     r_u;
    logic signed [U_W-1:0]     r_us;
    logic [DMAG_W-1:0]         r_dmag;
    logic                      r_d_neg;
    logic signed [ACC_W-1:0]   r_acc;
    logic [AW_W-1:0]           r_aw;
    logic signed [INTEG_W-1:0] r_integ;
    logic [15:0]               r_v;
    logic                      r_clip;
    logic                      r_db;
    logic [15:0]               r_out_v;
    logic                      r_out_clip;
    logic                      r_out_db;

    t_mul_req          mul_req;
    logic [PROD_W-1:0] prod;

    logic                      in_beat;
    logic                      out_free;
    logic signed [E_W-1:0]     e;
    logic signed [E_W-1:0]     ref_x;
    logic [E_W-1:0]            ref_mag;
    logic signed [U_W-1:0]     kpe;
    logic signed [U_W-1:0]     bound;
    logic signed [U_W-1:0]     us;
    logic signed [U_W-1:0]     d;
    logic signed [ACC_W-1:0]   kie;
    logic signed [ACC_W-1:0]   aw_s;
    logic signed [ACC_W-1:0]   nxt;
    logic signed [INTEG_W-1:0] nxt_sat;
    logic signed [U_W-1:0]     rnd;
    logic                      clip;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= KP_RST;
            r_ki   <= KI_TS_RST;
            r_kaw  <= KAW_TS_RST;
            r_vmax <= VMAX_RST;
            r_imin <= IMIN_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_KP:     r_kp   <= i_cfg_wdata[15:0];
                CFG_KI_TS:  r_ki   <= i_cfg_wdata;
                CFG_KAW_TS: r_kaw  <= i_cfg_wdata;
                CFG_VMAX:   r_vmax <= i_cfg_wdata[14:0];
                CFG_IMIN:   r_imin <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        mul_req = '0;
        case (r_state)
            ST_MKP: begin
                mul_req.a = {16'd0, r_kp};
                mul_req.b = {{(MUL_W-E_W){1'b0}}, r_emag};
            end
            ST_U: begin
                mul_req.a = r_ki;
                mul_req.b = {{(MUL_W-E_W){1'b0}}, r_emag};
            end
            ST_AWLO: begin
                mul_req.a = r_kaw;
                mul_req.b = r_dmag[MUL_W-1:0];
            end
            ST_AWHI: begin
                mul_req.a = r_kaw;
                mul_req.b = {{(2*MUL_W-DMAG_W){1'b0}}, r_dmag[DMAG_W-1:MUL_W]};
            end
            default: ;
        endcase
    end

    picc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // per-state arithmetic
    always_comb begin
        // error and deadband test
        e       = E_W'(r_ref) - E_W'(r_meas);
        ref_x   = E_W'(r_ref);
        ref_mag = ref_x[E_W-1] ? E_W'(-ref_x) : E_W'(ref_x);

        // kp*e moved to q.42, plus integrator
        kpe = $signed({3'd0, prod[MUL_W-1:0], 24'd0});
        if (r_e_neg) begin
            kpe = -kpe;
        end

        // clamp against vmax in q.42
        bound = $signed({12'd0, r_vmax, 32'd0});
        us    = r_u;
        clip  = 1'b0;
        if (r_u > bound) begin
            us   = bound;
            clip = 1'b1;
        end else if (r_u < -bound) begin
            us   = -bound;
            clip = 1'b1;
        end
        d = us - r_u;

        // ki*e term
        kie = $signed({13'd0, prod[48:0]});
        if (r_e_neg) begin
            kie = -kie;
        end

        // integrator update with saturation
        aw_s = $signed({2'd0, r_aw});
        if (r_d_neg) begin
            aw_s = -aw_s;
        end
        nxt = r_acc + aw_s;
        if ((&nxt[ACC_W-1:INTEG_W-1]) || !(|nxt[ACC_W-1:INTEG_W-1])) begin
            nxt_sat = nxt[INTEG_W-1:0];
        end else if (nxt[ACC_W-1]) begin
            nxt_sat = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            nxt_sat = {1'b0, {(INTEG_W-1){1'b1}}};
        end

        // round q.42 to q.10, ties toward +inf
        rnd = r_us + $signed({{(U_W-32){1'b0}}, 1'b1, 31'd0});
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_integ <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_ref   <= s_axis_tdata[15:0];
                        r_meas  <= s_axis_tdata[31:16];
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_e_neg <= e[E_W-1];
                    r_emag  <= e[E_W-1] ? E_W'(-e) : E_W'(e);
                    if (ref_mag < {2'd0, r_imin}) begin
                        r_integ <= '0;
                        r_v     <= '0;
                        r_clip  <= 1'b0;
                        r_db    <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        r_db    <= 1'b0;
                        r_state <= ST_MKP;
                    end
                end
                ST_MKP: begin
                    r_state <= ST_U;
                end
                ST_U: begin
                    r_u     <= kpe + U_W'(r_integ);
                    r_state <= ST_CLP;
                end
                ST_CLP: begin
                    r_us    <= us;
                    r_clip  <= clip;
                    r_d_neg <= d[U_W-1];
                    r_dmag  <= d[U_W-1] ? DMAG_W'(-d) : DMAG_W'(d);
                    r_acc   <= ACC_W'(r_integ) + kie;
                    r_state <= ST_AWLO;
                end
                ST_AWLO: begin
                    r_state <= ST_AWHI;
                end
                ST_AWHI: begin
                    // low partial product keeps only its upper half
                    r_aw    <= {{(AW_W-MUL_W){1'b0}}, prod[PROD_W-1:MUL_W]};
                    r_state <= ST_AWS;
                end
                ST_AWS: begin
                    r_aw    <= r_aw + {{(AW_W-DMAG_W){1'b0}}, prod[DMAG_W-1:0]};
                    r_state <= ST_INT;
                end
                ST_INT: begin
                    r_integ <= nxt_sat;
                    r_v     <= rnd[47:32];
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_out_v    <= r_v;
            r_out_clip <= r_clip;
            r_out_db   <= r_db;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_v;
    assign m_axis_tuser  = {r_out_db, r_out_clip};

    // checks
    `PICC_ASSERT_CLK(a_busy_after_beat, in_beat |=> !s_axis_tready)
    `PICC_ASSERT_CLK(a_deadband_zero,
        (m_axis_tvalid && m_axis_tuser[1]) |-> ((m_axis_tdata == 16'd0) && !m_axis_tuser[0]))
    `PICC_ASSERT_CLK(a_cmd_in_range,
        m_axis_tvalid |-> (($signed(m_axis_tdata) <= $signed({1'b0, r_vmax}))
            && ($signed(m_axis_tdata) >= -$signed({1'b0, r_vmax}))))
    `PICC_ASSERT_RST(a_integ_reset, !i_rst_n |=> (r_integ == '0))

endmodule
